// ----- hw/rtl/gbk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbk_pkg
// Types, constants and helpers shared by the GBK text to glyph command block.
// ----------------------------------------------------------------------------
package gbk_pkg;

    localparam int unsigned GLYPH_BYTES   = 32;
    localparam int unsigned GLYPH_WIDTH   = 16;
    localparam int unsigned ASCII_WIDTH   = 8;
    localparam int unsigned RIGHT_LIMIT   = 131;
    localparam int unsigned CODES_PER_ROW = 94;

    localparam logic [7:0] GB_LOW     = 8'hA1;
    localparam logic [7:0] GB_HIGH    = 8'hFE;
    localparam logic [7:0] HIGH_FIRST = 8'h80;
    localparam logic [7:0] PRINT_LOW  = 8'h20;

    typedef enum logic [1:0] {
        KIND_ASCII = 2'd0,
        KIND_GLYPH = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef struct packed {
        logic       first_byte;
        logic       last_byte;
        logic       draw_mode;
        logic [7:0] line_y;
        logic [7:0] start_x;
        logic [7:0] text_byte;
    } t_item;

    typedef struct packed {
        t_kind       cmd_kind;
        logic        run_end;
        logic        mode_out;
        logic [18:0] glyph_offset;
        logic [6:0]  char_code;
        logic [7:0]  pos_y;
        logic [7:0]  pos_x;
    } t_result;

    function automatic logic is_gb_byte(input logic [7:0] b);
        return (b >= GB_LOW) && (b <= GB_HIGH);
    endfunction

    function automatic logic fits(input logic [7:0] cur, input logic [8:0] width);
        logic [8:0] sum;
        sum = {1'b0, cur} + width;
        return sum <= 9'(RIGHT_LIMIT);
    endfunction

endpackage

// ----- hw/rtl/gbk_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbk_decode
// Line state, byte pairing and command build; up to two results per item.
// ----------------------------------------------------------------------------
module gbk_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  gbk_pkg::t_item   i_item,
    output gbk_pkg::t_result o_res0,
    output gbk_pkg::t_result o_res1,
    output logic [1:0]      o_count
);
    import gbk_pkg::*;

    localparam logic [8:0] GLYPH_W9 = 9'(GLYPH_WIDTH);
    localparam logic [8:0] ASCII_W9 = 9'(ASCII_WIDTH);

    logic [7:0] r_cursor, n_cursor;
    logic [7:0] r_row;
    logic       r_mode;
    logic [7:0] r_pending;
    logic       r_have_pending, n_have_pending;

    logic [7:0]  cur;
    logic [7:0]  row;
    logic        mode;
    logic        pend;
    logic        is_glyph;
    logic        is_ascii;
    logic        draw;
    logic [6:0]  hi_row;
    logic [6:0]  lo_col;
    logic [13:0] glyph_idx;
    logic [18:0] offs;
    t_result     draw_res;
    t_result     end_res;

    always_comb begin
        cur  = i_item.first_byte ? i_item.start_x   : r_cursor;
        row  = i_item.first_byte ? i_item.line_y    : r_row;
        mode = i_item.first_byte ? i_item.draw_mode : r_mode;
        pend = i_item.first_byte ? 1'b0             : r_have_pending;

        is_glyph = pend && is_gb_byte(r_pending) && is_gb_byte(i_item.text_byte)
                   && fits(cur, GLYPH_W9);
        is_ascii = !pend && (i_item.text_byte < HIGH_FIRST)
                   && (i_item.text_byte >= PRINT_LOW) && fits(cur, ASCII_W9);
        draw     = is_glyph || is_ascii;

        hi_row    = 7'(r_pending - GB_LOW);
        lo_col    = 7'(i_item.text_byte - GB_LOW);
        glyph_idx = 14'(hi_row) * 14'(CODES_PER_ROW) + 14'(lo_col);
        offs      = 19'(32'(glyph_idx) * GLYPH_BYTES);

        if (is_glyph) begin
            n_cursor = 8'(cur + 8'(GLYPH_WIDTH));
        end else if (is_ascii) begin
            n_cursor = 8'(cur + 8'(ASCII_WIDTH));
        end else begin
            n_cursor = cur;
        end
        n_have_pending = !pend && (i_item.text_byte >= HIGH_FIRST) && !i_item.last_byte;

        draw_res.cmd_kind     = is_glyph ? KIND_GLYPH : KIND_ASCII;
        draw_res.run_end      = !i_item.last_byte;
        draw_res.mode_out     = mode;
        draw_res.glyph_offset = is_glyph ? offs : 19'd0;
        draw_res.char_code    = is_glyph ? 7'd0 : i_item.text_byte[6:0];
        draw_res.pos_y        = row;
        draw_res.pos_x        = cur;

        end_res.cmd_kind     = KIND_END;
        end_res.run_end      = 1'b1;
        end_res.mode_out     = 1'b0;
        end_res.glyph_offset = 19'd0;
        end_res.char_code    = 7'd0;
        end_res.pos_y        = row;
        end_res.pos_x        = n_cursor;

        o_res0  = draw ? draw_res : end_res;
        o_res1  = end_res;
        o_count = 2'(draw) + 2'(i_item.last_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor       <= '0;
            r_row          <= '0;
            r_mode         <= 1'b0;
            r_have_pending <= 1'b0;
        end else if (i_accept) begin
            r_cursor       <= n_cursor;
            r_row          <= row;
            r_mode         <= mode;
            r_have_pending <= n_have_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pending <= i_item.text_byte;
        end
    end

`ifndef SYNTHESIS
    a_last_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.last_byte |=> !r_have_pending)
        else $error("pending byte kept past line end");

    a_two_results_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_count == 2'd2 |-> o_res0.cmd_kind != KIND_END && o_res1.cmd_kind == KIND_END)
        else $error("two results not a draw followed by line end");

    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && draw |=> r_cursor <= 8'(RIGHT_LIMIT))
        else $error("cursor advanced past right limit");
`endif

endmodule

// ----- hw/rtl/gbk_res_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbk_res_fifo
// Result queue: takes up to two results a cycle, gives at most one a cycle when popped.
// ----------------------------------------------------------------------------
module gbk_res_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_n,
    input  gbk_pkg::t_result i_res0,
    input  gbk_pkg::t_result i_res1,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_room2,
    output gbk_pkg::t_result o_res
);
    import gbk_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   wr_inc1;
    logic [PW-1:0]   wr_inc2;

    always_comb begin
        wr_inc1 = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
        wr_inc2 = (wr_inc1  == PW'(DEPTH - 1)) ? '0 : PW'(wr_inc1 + 1'b1);
        case (i_push_n)
            2'd1:    n_wr_ptr = wr_inc1;
            2'd2:    n_wr_ptr = wr_inc2;
            default: n_wr_ptr = r_wr_ptr;
        endcase
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
        end else begin
            n_rd_ptr = r_rd_ptr;
        end
        n_count = CW'(r_count + CW'(i_push_n) - CW'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_inc1] <= i_res1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= CW'(DEPTH - 2));
    assign o_res   = r_mem[r_rd_ptr];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_n != 2'd0 |-> ({1'b0, r_count} + (CW + 1)'(i_push_n)) <= (CW + 1)'(DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("result queue pop while empty");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 && i_push_n != 2'd0 |=> o_valid)
        else $error("pushed result not presented");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result count beyond depth");
`endif

endmodule

// ----- hw/rtl/gbk_text_to_glyph_commands.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbk_text_to_glyph_commands
// GBK text line bytes in, ASCII / glyph draw and line end commands out.
//
//  channel  dir  tdata                                   tuser     tlast
//  s_axis   in   text_byte, start_x, line_y, draw_mode   first     last_byte
//  m_axis   out  pos_x, pos_y, char_code, glyph_offset,  cmd_kind  run_end
//                mode_out
//
// One byte is accepted per cycle while the result queue has two free entries.
// Results enter the queue when the byte is accepted and leave one per cycle
// while m_axis_tready is high; a byte that ends a line after a draw gives
// two results, so the queue of OUT_DEPTH entries sets the stall point.
// Synchronous reset clears the cursor, pending byte and queue.
// ----------------------------------------------------------------------------
module gbk_text_to_glyph_commands #(
    parameter int unsigned OUT_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // text_byte, start_x, line_y, draw_mode, pad
    input  logic [0:0]  s_axis_tuser,   // first_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // pos_x, pos_y, char_code, glyph_offset, mode_out, pad
    output logic [1:0]  m_axis_tuser,   // cmd_kind
    output logic        m_axis_tlast
);
    import gbk_pkg::*;

    logic       accept;
    logic       room2;
    logic [1:0] res_count;
    logic [1:0] push_n;
    t_item      item;
    t_result    res0;
    t_result    res1;
    t_result    res_out;

    assign s_axis_tready = room2 && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_n        = accept ? res_count : 2'd0;

    always_comb begin
        item.text_byte  = s_axis_tdata[7:0];
        item.start_x    = s_axis_tdata[15:8];
        item.line_y     = s_axis_tdata[23:16];
        item.draw_mode  = s_axis_tdata[24];
        item.first_byte = s_axis_tuser[0];
        item.last_byte  = s_axis_tlast;
    end

    gbk_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (item),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_count (res_count)
    );

    gbk_res_fifo #(
        .DEPTH(OUT_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push_n(push_n),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_pop   (m_axis_tvalid && m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_room2 (room2),
        .o_res   (res_out)
    );

    assign m_axis_tdata = {5'd0, res_out.mode_out, res_out.glyph_offset,
                           res_out.char_code, res_out.pos_y, res_out.pos_x};
    assign m_axis_tuser = res_out.cmd_kind;
    assign m_axis_tlast = res_out.run_end;

endmodule

// ----- tb/sv/gbk_text_to_glyph_commands_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbk_text_to_glyph_commands_test
// Drives GBK text lines into the glyph command block byte by byte. A
// scoreboard keeps its own cursor, row, mode and pending high byte, predicts
// the draw and line end commands of every accepted byte and compares each
// output item field by field. Directed lines cover the edge cases; random
// lines of ASCII, valid pairs, broken pairs and noise follow, with random
// gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module gbk_text_to_glyph_commands_test;

    import gbk_pkg::*;

    class glyph_cmd_scoreboard;
        logic [7:0] cursor_col;
        logic [7:0] row_pos;
        logic       held_mode;
        logic [7:0] pending_high;
        logic       have_pending;
        t_result    expected_cmds[$];
        int         mismatches;

        function new();
            cursor_col   = '0;
            row_pos      = '0;
            held_mode    = 1'b0;
            pending_high = '0;
            have_pending = 1'b0;
            mismatches   = 0;
        endfunction

        function int outstanding();
            return expected_cmds.size();
        endfunction

        function logic in_gb_range(logic [7:0] b);
            return b >= GB_LOW && b <= GB_HIGH;
        endfunction

        function logic room_for(int unsigned width);
            return int'(cursor_col) + int'(width) <= int'(RIGHT_LIMIT);
        endfunction

        function t_result make_cmd(t_kind kind, logic [6:0] code, logic [18:0] offs,
                                   logic mode);
            t_result r;
            r.cmd_kind     = kind;
            r.pos_x        = cursor_col;
            r.pos_y        = row_pos;
            r.char_code    = code;
            r.glyph_offset = offs;
            r.mode_out     = mode;
            r.run_end      = 1'b0;
            return r;
        endfunction

        function void note_byte(t_item it);
            t_result     cmds[$];
            logic [7:0]  hi;
            int unsigned offs;
            if (it.first_byte) begin
                cursor_col   = it.start_x;
                row_pos      = it.line_y;
                held_mode    = it.draw_mode;
                have_pending = 1'b0;
                pending_high = '0;
            end
            if (have_pending) begin
                hi           = pending_high;
                have_pending = 1'b0;
                pending_high = '0;
                if (in_gb_range(hi) && in_gb_range(it.text_byte) && room_for(GLYPH_WIDTH)) begin
                    offs = ((int'(hi) - int'(GB_LOW)) * CODES_PER_ROW +
                            (int'(it.text_byte) - int'(GB_LOW))) * GLYPH_BYTES;
                    cmds.push_back(make_cmd(KIND_GLYPH, '0, 19'(offs), held_mode));
                    cursor_col = cursor_col + 8'(GLYPH_WIDTH);
                end
            end else if (it.text_byte < HIGH_FIRST) begin
                if (it.text_byte >= PRINT_LOW && room_for(ASCII_WIDTH)) begin
                    cmds.push_back(make_cmd(KIND_ASCII, it.text_byte[6:0], '0, held_mode));
                    cursor_col = cursor_col + 8'(ASCII_WIDTH);
                end
            end else if (!it.last_byte) begin
                pending_high = it.text_byte;
                have_pending = 1'b1;
            end
            if (it.last_byte) begin
                have_pending = 1'b0;
                pending_high = '0;
                cmds.push_back(make_cmd(KIND_END, '0, '0, 1'b0));
            end
            if (cmds.size() > 0) begin
                cmds[cmds.size() - 1].run_end = 1'b1;
            end
            foreach (cmds[i]) begin
                expected_cmds.push_back(cmds[i]);
            end
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act) begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_cmd(logic [47:0] data, logic [1:0] user, logic last);
            t_result e;
            if (expected_cmds.size() == 0) begin
                $error("command item with nothing expected: tdata %h tuser %0d", data, user);
                mismatches++;
                return;
            end
            e = expected_cmds.pop_front();
            compare_field("cmd_kind", 32'(e.cmd_kind), 32'(user));
            compare_field("pos_x", 32'(e.pos_x), 32'(data[7:0]));
            compare_field("pos_y", 32'(e.pos_y), 32'(data[15:8]));
            compare_field("char_code", 32'(e.char_code), 32'(data[22:16]));
            compare_field("glyph_offset", 32'(e.glyph_offset), 32'(data[41:23]));
            compare_field("mode_out", 32'(e.mode_out), 32'(data[42]));
            compare_field("run_end", 32'(e.run_end), 32'(last));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // text_byte, start_x, line_y, draw_mode, pad
    logic [0:0]  s_axis_tuser = '0;    // first_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // pos_x, pos_y, char_code, glyph_offset, mode_out, pad
    logic [1:0]  m_axis_tuser;         // cmd_kind
    logic        m_axis_tlast;

    glyph_cmd_scoreboard sb;
    int                  bytes_sent;

    gbk_text_to_glyph_commands i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [7:0] sx, input logic [7:0] y,
                             input logic m, input logic f, input logic l);
        t_item       it;
        int unsigned gap;
        it.text_byte  = b;
        it.start_x    = sx;
        it.line_y     = y;
        it.draw_mode  = m;
        it.first_byte = f;
        it.last_byte  = l;
        s_axis_tdata  <= {7'd0, m, y, sx, b};
        s_axis_tuser  <= f;
        s_axis_tlast  <= l;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(it);
        bytes_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic send_line();
        logic [7:0]  text[$];
        int unsigned units;
        int unsigned r;
        logic [7:0]  sx;
        logic [7:0]  y;
        logic        m;
        logic        mark_first;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 4)) begin
                send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            return;
        end
        sx         = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 120))
                                                  : 8'($urandom_range(0, 255));
        y          = 8'($urandom_range(0, 255));
        m          = 1'($urandom_range(0, 1));
        mark_first = $urandom_range(0, 99) < 92;
        units      = $urandom_range(1, 14);
        repeat (units) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                text.push_back(8'($urandom_range(8'h20, 8'h7F)));
            end else if (r < 80) begin
                text.push_back(8'($urandom_range(GB_LOW, GB_HIGH)));
                text.push_back(8'($urandom_range(GB_LOW, GB_HIGH)));
            end else if (r < 88) begin
                text.push_back(8'($urandom_range(0, 8'h1F)));
            end else if (r < 94) begin
                text.push_back(8'($urandom_range(HIGH_FIRST, 8'hFF)));
                text.push_back(8'($urandom_range(0, 255)));
            end else begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 99) < 15) begin
            text.push_back(8'($urandom_range(HIGH_FIRST, 8'hFF)));
        end
        foreach (text[i]) begin
            if (i == 0) begin
                send_byte(text[i], sx, y, m, mark_first, text.size() == 1);
            end else begin
                send_byte(text[i], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0, i == text.size() - 1);
            end
        end
    endtask

    initial begin
        int unsigned stall;
        forever begin
            stall = $urandom_range(0, 99);
            if (stall < 60) begin
                stall = 0;
            end else if (stall < 90) begin
                stall = $urandom_range(1, 3);
            end else begin
                stall = $urandom_range(10, 40);
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_cmd(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    initial begin
        sb         = new();
        bytes_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(8'h41, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h7E, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0);
        send_byte(PRINT_LOW, 8'd123, 8'hAA, 1'b1, 1'b1, 1'b0);
        send_byte(8'h21, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h1F, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h00, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(GB_LOW, 8'd0, 8'h55, 1'b0, 1'b1, 1'b0);
        send_byte(GB_LOW, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(GB_HIGH, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(GB_HIGH, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(HIGH_FIRST, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h41, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(8'hA0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(GB_LOW, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(GB_LOW, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(8'hFF, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(8'hB0, 8'd115, 8'd3, 1'b1, 1'b1, 1'b0);
        send_byte(GB_LOW, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(8'hC0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(8'hC1, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(8'hD6, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h7F, 8'd10, 8'd20, 1'b1, 1'b1, 1'b0);
        send_byte(8'h81, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);
        send_byte(8'h5A, 8'd50, 8'd200, 1'b1, 1'b1, 1'b1);
        send_byte(8'h0A, 8'd60, 8'd1, 1'b0, 1'b1, 1'b1);
        send_byte(8'hC4, 8'd0, 8'd9, 1'b1, 1'b1, 1'b0);
        send_byte(8'hE3, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);

        s_axis_tvalid <= 1'b0;
        wait_drained();

        bytes_sent = 0;
        while (bytes_sent < 450) begin
            send_line();
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("gbk_text_to_glyph_commands_test passed");
        end else begin
            $display("gbk_text_to_glyph_commands_test failed");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("gbk_text_to_glyph_commands_test failed");
        $finish;
    end

endmodule
